>>> src/csa_pkg.sv
package csa_pkg;

	localparam int CoordBits = 24;
	localparam int WeightBits = 17;
	localparam int AccBits = 64;
	localparam int SubdivBits = 7;
	localparam int MaxSubdivDefault = 64;
	localparam int DivSteps = 17;
	localparam logic [SubdivBits-1:0] SubdivReset = SubdivBits'(16);
	localparam logic [WeightBits-1:0] OneQ16 = WeightBits'(65536);

	typedef enum logic [1:0] {
		EDGE_LINEAR = 2'd0,
		EDGE_QUAD   = 2'd1,
		EDGE_CUBIC  = 2'd2,
		EDGE_NONE   = 2'd3
	} edge_kind_t;

	typedef struct packed {
		logic [1:0]                  edge_type;
		logic signed [CoordBits-1:0] p0_x;
		logic signed [CoordBits-1:0] p0_y;
		logic signed [CoordBits-1:0] p1_x;
		logic signed [CoordBits-1:0] p1_y;
		logic signed [CoordBits-1:0] p2_x;
		logic signed [CoordBits-1:0] p2_y;
		logic signed [CoordBits-1:0] p3_x;
		logic signed [CoordBits-1:0] p3_y;
		logic                        last_edge;
	} in_item_t;

	typedef struct packed {
		logic signed [AccBits-1:0] signed_area;
		logic                      area_negative;
		logic                      saturated;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic init;
		logic w1;
		logic w2;
		logic pm;
		logic ps;
		logic xm;
		logic a1;
		logic a2;
		logic advance;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_ok;
		logic div_done;
		logic chord_last;
	} sts_t;

endpackage

>>> src/csa_dp.sv
module csa_dp #(
	parameter int MaxSubdiv = csa_pkg::MaxSubdivDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csa_pkg::in_item_t                   in_data,
	input  logic                                cfg_we,
	input  logic [csa_pkg::SubdivBits-1:0]      cfg_data,
	input  csa_pkg::cmd_t                       cmd,
	output csa_pkg::sts_t                       sts,
	output csa_pkg::out_item_t                  out_data
);

	localparam int CW = csa_pkg::CoordBits;
	localparam int WB = csa_pkg::WeightBits;
	localparam int NW = $clog2(MaxSubdiv + 1);
	localparam int PW = WB + 1 + CW;
	localparam int SW = PW + 2;
	localparam int AB = csa_pkg::AccBits;

	logic [csa_pkg::SubdivBits-1:0] subdiv_q;
	logic [8:0]                     sub_ext;
	logic [8:0]                     max_ext;
	logic [8:0]                     n_sel;
	logic [NW-1:0]                  n;
	logic [NW:0]                    n_ext;

	logic signed [CW-1:0] px_q [4];
	logic signed [CW-1:0] py_q [4];
	logic signed [CW-1:0] prev_x_q, prev_y_q, q_x_q, q_y_q;

	logic [4:0]    div_cnt_q;
	logic [NW-1:0] div_rem_q;
	logic [WB-1:0] div_quo_q;
	logic          div_ok_q;
	logic [NW:0]   r_sh;
	logic          r_ge;
	logic [NW-1:0] r_new;

	logic [NW-1:0] i_q;
	logic [WB-1:0] t_q;
	logic [NW-1:0] rem_q;
	logic [NW:0]   rsum;
	logic          carry;
	logic [WB-1:0] u;

	logic [2*WB-1:0] uu, ut, tt, m0, m1, m2, m3;
	logic [2*WB+1:0] m1x3, m2x3;
	logic [WB-1:0]   u2_q, t2_q;
	logic [WB-1:0]   w_q [4];

	logic signed [PW-1:0]   prx_s2 [4];
	logic signed [PW-1:0]   pry_s2 [4];
	logic signed [SW-1:0]   sx, sy;
	logic signed [2*CW-1:0] mab_s3, mba_s3;

	logic signed [AB-1:0] acc_q;
	logic                 ovf_q;
	logic signed [AB:0]   term;
	logic signed [AB:0]   sum;

	assign sub_ext = {2'b00, subdiv_q};
	assign max_ext = 9'(MaxSubdiv);

	always_comb begin
		if (sub_ext == 9'd0) begin
			n_sel = 9'd1;
		end else if (sub_ext > max_ext) begin
			n_sel = max_ext;
		end else begin
			n_sel = sub_ext;
		end
	end

	assign n     = NW'(n_sel);
	assign n_ext = {1'b0, n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subdiv_q <= csa_pkg::SubdivReset;
			div_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				subdiv_q <= cfg_data;
				div_ok_q <= 1'b0;
			end else if (cmd.div_step && sts.div_done) begin
				div_ok_q <= 1'b1;
			end
		end
	end

	assign r_sh  = {div_rem_q, div_cnt_q == 5'd0};
	assign r_ge  = r_sh >= n_ext;
	assign r_new = r_ge ? NW'(r_sh - n_ext) : NW'(r_sh);

	always_ff @(posedge clk) begin
		if (cmd.load && !div_ok_q) begin
			div_cnt_q <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			div_rem_q <= r_new;
			div_quo_q <= {div_quo_q[WB-2:0], r_ge};
		end
	end

	assign rsum  = {1'b0, rem_q} + {1'b0, div_rem_q};
	assign carry = rsum >= n_ext;
	assign u     = csa_pkg::OneQ16 - t_q;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			i_q   <= NW'(1);
			t_q   <= div_quo_q;
			rem_q <= div_rem_q;
		end else if (cmd.advance) begin
			i_q   <= i_q + NW'(1);
			t_q   <= t_q + div_quo_q + WB'(carry);
			rem_q <= carry ? NW'(rsum - n_ext) : NW'(rsum);
		end
	end

	assign uu   = u * u;
	assign ut   = u * t_q;
	assign tt   = t_q * t_q;
	assign m0   = u2_q * u;
	assign m1   = u2_q * t_q;
	assign m2   = u * t2_q;
	assign m3   = t2_q * t_q;
	assign m1x3 = {1'b0, m1, 1'b0} + {2'b00, m1};
	assign m2x3 = {1'b0, m2, 1'b0} + {2'b00, m2};

	always_ff @(posedge clk) begin
		if (cmd.w1) begin
			u2_q   <= uu[2*WB-2:WB-1];
			t2_q   <= tt[2*WB-2:WB-1];
			w_q[0] <= uu[2*WB-2:WB-1];
			w_q[1] <= ut[2*WB-3:WB-2];
			w_q[2] <= tt[2*WB-2:WB-1];
			w_q[3] <= '0;
		end else if (cmd.w2) begin
			w_q[0] <= m0[2*WB-2:WB-1];
			w_q[1] <= m1x3[2*WB-2:WB-1];
			w_q[2] <= m2x3[2*WB-2:WB-1];
			w_q[3] <= m3[2*WB-2:WB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pm) begin
			for (int k = 0; k < 4; k++) begin
				prx_s2[k] <= $signed({1'b0, w_q[k]}) * px_q[k];
				pry_s2[k] <= $signed({1'b0, w_q[k]}) * py_q[k];
			end
		end
	end

	assign sx = SW'(prx_s2[0]) + SW'(prx_s2[1]) + SW'(prx_s2[2]) + SW'(prx_s2[3]);
	assign sy = SW'(pry_s2[0]) + SW'(pry_s2[1]) + SW'(pry_s2[2]) + SW'(pry_s2[3]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q[0]  <= in_data.p0_x;
			py_q[0]  <= in_data.p0_y;
			px_q[1]  <= in_data.p1_x;
			py_q[1]  <= in_data.p1_y;
			px_q[2]  <= in_data.p2_x;
			py_q[2]  <= in_data.p2_y;
			px_q[3]  <= in_data.p3_x;
			py_q[3]  <= in_data.p3_y;
			prev_x_q <= in_data.p0_x;
			prev_y_q <= in_data.p0_y;
			q_x_q    <= in_data.p1_x;
			q_y_q    <= in_data.p1_y;
		end else begin
			if (cmd.ps) begin
				q_x_q <= sx[CW+15:16];
				q_y_q <= sy[CW+15:16];
			end
			if (cmd.a2) begin
				prev_x_q <= q_x_q;
				prev_y_q <= q_y_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.xm) begin
			mab_s3 <= prev_x_q * q_y_q;
			mba_s3 <= q_x_q * prev_y_q;
		end
	end

	assign term = cmd.a2 ? -((AB+1)'(mba_s3)) : (AB+1)'(mab_s3);
	assign sum  = {acc_q[AB-1], acc_q} + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.emit) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.a1 || cmd.a2) begin
			if (sum[AB] != sum[AB-1]) begin
				acc_q <= sum[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
				ovf_q <= 1'b1;
			end else begin
				acc_q <= sum[AB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data.signed_area   <= {acc_q[AB-1], acc_q[AB-1:1]};
			out_data.area_negative <= acc_q[AB-1];
			out_data.saturated     <= ovf_q;
		end
	end

	assign sts.div_ok     = div_ok_q;
	assign sts.div_done   = div_cnt_q == 5'(csa_pkg::DivSteps - 1);
	assign sts.chord_last = i_q == n;

endmodule

>>> src/csa_ctrl.sv
module csa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    in_edge_type,
	input  logic          in_last,
	output logic          out_valid,
	input  logic          out_stall,
	input  csa_pkg::sts_t sts,
	output csa_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_DIV  = 11'b00000000010,
		S_INIT = 11'b00000000100,
		S_W1   = 11'b00000001000,
		S_W2   = 11'b00000010000,
		S_PM   = 11'b00000100000,
		S_PS   = 11'b00001000000,
		S_XM   = 11'b00010000000,
		S_A1   = 11'b00100000000,
		S_A2   = 11'b01000000000,
		S_EMIT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   cubic_q, curve_q, last_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (in_edge_type) inside
						csa_pkg::EDGE_LINEAR: state_d = S_XM;
						csa_pkg::EDGE_QUAD, csa_pkg::EDGE_CUBIC:
							state_d = sts.div_ok ? S_INIT : S_DIV;
						default: state_d = in_last ? S_EMIT : S_IDLE;
					endcase
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_W1;
			end
			S_W1: begin
				cmd.w1  = 1'b1;
				state_d = cubic_q ? S_W2 : S_PM;
			end
			S_W2: begin
				cmd.w2  = 1'b1;
				state_d = S_PM;
			end
			S_PM: begin
				cmd.pm  = 1'b1;
				state_d = S_PS;
			end
			S_PS: begin
				cmd.ps  = 1'b1;
				state_d = S_XM;
			end
			S_XM: begin
				cmd.xm  = 1'b1;
				state_d = S_A1;
			end
			S_A1: begin
				cmd.a1  = 1'b1;
				state_d = S_A2;
			end
			S_A2: begin
				cmd.a2 = 1'b1;
				if (curve_q && !sts.chord_last) begin
					cmd.advance = 1'b1;
					state_d     = S_W1;
				end else begin
					state_d = last_q ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cubic_q     <= 1'b0;
			curve_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cubic_q <= in_edge_type == csa_pkg::EDGE_CUBIC;
				curve_q <= in_edge_type == csa_pkg::EDGE_QUAD
					|| in_edge_type == csa_pkg::EDGE_CUBIC;
				last_q  <= in_last;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/contour_signed_area.sv
// Linear edge: after acceptance the XM, A1 and A2 steps run before the next input is taken.
// Curved edge: an init step, then for each of N chords the W1 weight step (plus W2 for cubic),
// the PM and PS point steps, the XM cross-product step and the A1 and A2 accumulate steps.
// The first curve after reset or a subdivisions write first runs the divider steps.
// The last edge adds an emit step to load the output register, which waits while a held result is stalled.
// arst_n clears the sum and the saturation flag and sets subdivisions to 16.
module contour_signed_area #(
	parameter int MAX_SUBDIVISIONS = csa_pkg::MaxSubdivDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  csa_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output csa_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [csa_pkg::SubdivBits-1:0] cfg_data
);

	csa_pkg::cmd_t cmd;
	csa_pkg::sts_t sts;

	csa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_edge_type (in_data.edge_type),
		.in_last      (in_data.last_edge),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	csa_dp #(
		.MaxSubdiv (MAX_SUBDIVISIONS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

>>> src/csa_chk.sv
module csa_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input csa_pkg::in_item_t              in_data,
	input logic                           out_valid,
	input logic                           out_stall,
	input csa_pkg::out_item_t             out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_sign_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.area_negative == out_data.signed_area[63])
		else $error("negative flag disagrees with area");

	a_busy_after_edge: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.edge_type != csa_pkg::EDGE_NONE |=> in_stall)
		else $error("new item taken while an edge is in work");

endmodule

bind contour_signed_area csa_chk u_chk (.*);
